[rtl/core/kvi_pkg.sv]
// Package for the keyframe vertex interpolator: request and result payload
// structs, the configuration struct and the register index codes.
// No dependencies; every other file of the block uses it by scoped names.
package kvi_pkg;

    localparam int unsigned FRAME_W    = 12;
    localparam int unsigned FRAC_W     = 4;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned OUT_W      = 24;
    localparam int unsigned FRACTION_W = 8;
    localparam int unsigned POS_W      = 21;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // Largest number of fraction bits; larger register values clamp to it.
    localparam logic [FRAC_W-1:0] MAX_FRAC = 4'd8;

    // Register index codes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_FRAME = 2'd0,
        REG_END_FRAME   = 2'd1,
        REG_FRAC_BITS   = 2'd2,
        REG_FRAME_STEP  = 2'd3
    } cfg_index_t;

    // Request modes.
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_VERTEX = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] cur_value;
        logic signed [VALUE_W-1:0] next_value;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]   out_value;
        logic [FRAME_W-1:0]        key_frame;
        logic [FRAME_W-1:0]        next_key_frame;
        logic [FRACTION_W-1:0]     fraction;
    } out_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] start_frame;
        logic [FRAME_W-1:0] end_frame;
        logic [FRAC_W-1:0]  frac_bits;
        logic [STEP_W-1:0]  frame_step;
    } cfg_t;

endpackage

[rtl/core/kvi_step.sv]
// Combinational step of the keyframe vertex interpolator: position update for
// ticks, key frame report, and the vertex interpolation multiply.
// Depends on kvi_pkg.
module kvi_step
(
    input  kvi_pkg::cfg_t                 cfg,
    input  logic [kvi_pkg::POS_W-1:0]     position,
    input  kvi_pkg::in_item_t             item,
    output logic [kvi_pkg::POS_W-1:0]     position_next,
    output kvi_pkg::out_item_t            result
);

    logic [kvi_pkg::FRAC_W-1:0] frac_eff;
    logic signed [23:0]         lo_pos;
    logic signed [23:0]         hi_pos;
    logic signed [23:0]         span_pos;
    logic signed [23:0]         sum_pos;
    logic signed [23:0]         wrap_pos;
    logic signed [23:0]         new_pos;
    logic [kvi_pkg::POS_W-1:0]  rep_pos;
    logic [kvi_pkg::POS_W-1:0]  key_full;
    logic [kvi_pkg::POS_W:0]    key_inc;
    logic [kvi_pkg::POS_W-1:0]  frac_mask;
    logic [kvi_pkg::FRACTION_W-1:0] frac_val;
    logic signed [16:0]         diff;
    logic signed [25:0]         prod;
    logic signed [25:0]         scaled;
    logic signed [25:0]         interp;

    always_comb
    begin
        frac_eff = (cfg.frac_bits > kvi_pkg::MAX_FRAC) ? kvi_pkg::MAX_FRAC : cfg.frac_bits;

        lo_pos   = $signed({12'd0, cfg.start_frame}) <<< frac_eff;
        hi_pos   = $signed({12'd0, cfg.end_frame}) <<< frac_eff;
        // The span is negative when start lies above end.
        span_pos = ($signed({12'd0, cfg.end_frame}) - $signed({12'd0, cfg.start_frame}))
                   <<< frac_eff;
        sum_pos  = $signed({3'd0, position}) + $signed({16'd0, cfg.frame_step});

        wrap_pos = (sum_pos >= hi_pos) ? (sum_pos - span_pos) : sum_pos;
        new_pos  = ((wrap_pos < lo_pos) || (wrap_pos >= hi_pos)) ? lo_pos : wrap_pos;
        position_next = new_pos[kvi_pkg::POS_W-1:0];

        // Ticks report the updated position, vertex requests the stored one.
        rep_pos   = (item.mode == kvi_pkg::MODE_TICK) ? position_next : position;
        key_full  = rep_pos >> frac_eff;
        key_inc   = {1'b0, key_full} + 22'd1;
        frac_mask = (21'd1 << frac_eff) - 21'd1;
        frac_val  = rep_pos[kvi_pkg::FRACTION_W-1:0] & frac_mask[kvi_pkg::FRACTION_W-1:0];

        diff   = $signed({item.next_value[15], item.next_value})
               - $signed({item.cur_value[15], item.cur_value});
        prod   = $signed({{9{diff[16]}}, diff}) * $signed({18'd0, frac_val});
        scaled = prod >>> frac_eff;
        interp = scaled + $signed({{10{item.cur_value[15]}}, item.cur_value});

        result.out_value      = (item.mode == kvi_pkg::MODE_VERTEX)
                              ? $signed({interp[15:0], 8'h00}) : '0;
        result.key_frame      = key_full[kvi_pkg::FRAME_W-1:0];
        result.next_key_frame = (key_inc > {10'd0, cfg.end_frame})
                              ? cfg.start_frame : key_inc[kvi_pkg::FRAME_W-1:0];
        result.fraction       = frac_val;
    end

endmodule

[rtl/core/keyframe_vertex_interpolator_core.sv]
// Top level of the keyframe vertex interpolator: request register, result
// register, animation position and configuration registers.
// Depends on kvi_pkg and kvi_step.

// The block keeps a looping fixed-point animation position and answers one
// result per request. A tick request (mode 0) advances the position by
// frame_step, wraps it inside [start_frame, end_frame) and reports the key
// frame, the next key frame and the fraction; its out_value is zero. A vertex
// request (mode 1) blends the current and next key-frame components with the
// stored fraction and returns the result shifted left by eight bits, leaving
// the position alone. Throughput is one request per clock cycle while the
// consumer does not stall. A request passes through the request register
// and then the result register, which drives out_valid; a stall can hold
// it in either. The position update, the report and the single 17 by 8 bit
// multiply all sit in the one stage between those two registers, and the
// position register is written in the same cycle a tick moves to the result
// register, so consecutive ticks see each other without bubbles. The result
// register holds a stalled result while the request register can still
// take one new request if it is empty. Configuration registers must only be
// written while the block holds no request.
module keyframe_vertex_interpolator_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  kvi_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output kvi_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [kvi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kvi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    kvi_pkg::cfg_t              cfg_reg;
    kvi_pkg::in_item_t          req_reg;
    logic                       req_valid_reg;
    kvi_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;
    logic [kvi_pkg::POS_W-1:0]  position_reg;
    logic [kvi_pkg::POS_W-1:0]  position_next;
    kvi_pkg::out_item_t         result;
    logic                       out_free;
    logic                       req_advance;

    // The result register accepts a new result when empty or being drained.
    assign out_free    = !out_valid_reg || out_ready;
    assign req_advance = req_valid_reg && out_free;
    assign in_ready    = !req_valid_reg || req_advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_frame <= 12'd0;
            cfg_reg.end_frame   <= 12'd1;
            cfg_reg.frac_bits   <= 4'd4;
            cfg_reg.frame_step  <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (kvi_pkg::cfg_index_t'(cfg_index))
                kvi_pkg::REG_START_FRAME: cfg_reg.start_frame <= cfg_data[11:0];
                kvi_pkg::REG_END_FRAME:   cfg_reg.end_frame   <= cfg_data[11:0];
                kvi_pkg::REG_FRAC_BITS:   cfg_reg.frac_bits   <= cfg_data[3:0];
                kvi_pkg::REG_FRAME_STEP:  cfg_reg.frame_step  <= cfg_data[7:0];
                default:                  cfg_reg.frame_step  <= cfg_reg.frame_step;
            endcase
        end
    end

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

    kvi_step u_step
    (
        .cfg           (cfg_reg),
        .position      (position_reg),
        .item          (req_reg),
        .position_next (position_next),
        .result        (result)
    );

    // Position register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_advance && (req_reg.mode == kvi_pkg::MODE_TICK))
            begin
                position_reg <= position_next;
            end
            if (out_free)
            begin
                out_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_advance)
        begin
            out_reg <= result;
        end
    end

    // The position always fits in twenty bits, as start_frame and end_frame shifted by at most eight bits do.
    assert property (@(posedge clk) disable iff (!rst_n)
        position_reg[kvi_pkg::POS_W-1] == 1'b0)
        else $error("position left its twenty-bit range");

    // Only a tick leaving the request register moves the position.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req_advance && (req_reg.mode == kvi_pkg::MODE_TICK)) |=> $stable(position_reg))
        else $error("position changed without a tick");

    // An empty request register must always take a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid_reg |-> in_ready)
        else $error("request register empty but not ready");

    // A held result must not be overwritten while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_free)
        else $error("stalled result register marked free");

endmodule
